[src/multi_bulk_bump_allocator_unit_defines.svh]
// Assertion macros for the bump allocator unit.
// Included by the top level; no other dependencies.
`ifndef MULTI_BULK_BUMP_ALLOCATOR_UNIT_DEFINES_SVH
`define MULTI_BULK_BUMP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MBBA_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
`define MBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MBBA_ASSERT_NEVER(label, clk, rst_n, cond)
`define MBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/mbba_pkg.sv]
// Shared types and constants of the bump allocator unit.
// No dependencies.
package mbba_pkg;
	localparam int BASE_W = 40;
	localparam int SIZE_W = 34;
	localparam int NB_W   = 41;
	localparam int CFG_W  = 41;
	localparam int REQ_W  = 32;

	localparam logic [1:0] REG_BULK    = 2'd0;
	localparam logic [1:0] REG_INITIAL = 2'd1;
	localparam logic [1:0] REG_REGION  = 2'd2;

	localparam logic [1:0] ST_GRANT    = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_REGION   = 2'd2;
	localparam logic [1:0] ST_FREE_ALL = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RND_INIT,
		OP_RND_REQ,
		OP_RND_STEP,
		OP_INIT_PUT,
		OP_FREE_ALL,
		OP_SCAN_STEP,
		OP_SWAP_WR,
		OP_INSERT,
		OP_RES_FULL,
		OP_RES_REGION,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		logic started;
		logic func;
		logic rnd_done;
		logic carve_fail;
		logic scan_end;
		logic scan_hit;
		logic hit_swap;
		logic table_full;
		logic live_over;
	} dp_stat_t;
endpackage

[src/mbba_datapath.sv]
// Datapath: config registers, bulk table, rounding unit and result registers.
// Depends on mbba_pkg.
module mbba_datapath #(
	parameter int MAX_BULKS  = 16,
	parameter int WORD_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mbba_pkg::dp_op_t            op,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [mbba_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        func,
	input  logic [mbba_pkg::REQ_W-1:0]  request_bytes,
	output mbba_pkg::dp_stat_t          st,
	output logic [mbba_pkg::BASE_W-1:0] address,
	output logic [1:0]                  status
);
	import mbba_pkg::*;

	localparam int IDX_W = (MAX_BULKS > 1) ? $clog2(MAX_BULKS) : 1;
	localparam int CNT_W = $clog2(MAX_BULKS + 1);
	localparam int REM_W = $clog2(WORD_BYTES) + 1;
	localparam int STEP_W = 2;
	localparam int S1_W = $clog2(SIZE_W * WORD_BYTES) + 1;
	localparam int S2_W = $clog2(S1_W * WORD_BYTES) + 1;
	localparam logic [REM_W-1:0] W_R = REM_W'(WORD_BYTES);
	localparam logic [SIZE_W-1:0] W_S = SIZE_W'(WORD_BYTES);

	// Residue of 2^b modulo the word size
	function automatic int unsigned pow2_mod(int b);
		int unsigned r;
		r = 1 % WORD_BYTES;
		for (int i = 0; i < b; i++) r = (r * 2) % WORD_BYTES;
		return r;
	endfunction

	logic [32:0]        bulk_bytes_q, initial_bytes_q;
	logic [NB_W-1:0]    region_q;
	logic [BASE_W-1:0]  base_q [MAX_BULKS];
	logic [SIZE_W-1:0]  cap_q  [MAX_BULKS];
	logic [SIZE_W-1:0]  free_q [MAX_BULKS];
	logic [CNT_W-1:0]   total_q, live_q, idx_q;
	logic [NB_W-1:0]    nb_q;
	logic               started_q, func_q, bypass_q;
	logic [REQ_W-1:0]   req_q;
	logic [SIZE_W-1:0]  rnd_n_q;
	logic [S1_W-1:0]    s1_q;
	logic [S2_W-1:0]    s2_q;
	logic [REM_W-1:0]   rem_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [BASE_W-1:0]  res_addr_q, address_q;
	logic [1:0]         res_status_q, status_q;

	logic [S1_W-1:0]    s1_nx;
	logic [S2_W-1:0]    s2_nx;
	logic [REM_W-1:0]   rem_nx;
	logic [SIZE_W-1:0]  rnd_res, init_cap, new_cap, carve_cap;
	logic [NB_W:0]      carve_sum;
	logic [IDX_W-1:0]   ri, rj;
	logic [SIZE_W-1:0]  rd_free, rd_cap, new_free;
	logic [BASE_W-1:0]  rd_base;
	logic [SIZE_W-1:0]  req_eff;

	// Rounding: fold the operand into bit residues, fold again, then strip multiples
	always_comb begin
		s1_nx = '0;
		for (int b = 0; b < SIZE_W; b++) begin
			if (rnd_n_q[b]) s1_nx = s1_nx + S1_W'(pow2_mod(b));
		end
		s2_nx = '0;
		for (int b = 0; b < S1_W; b++) begin
			if (s1_q[b]) s2_nx = s2_nx + S2_W'(pow2_mod(b));
		end
		rem_nx = REM_W'(s2_q);
		for (int k = 1; k <= S1_W; k++) begin
			if (s2_q >= S2_W'(k * WORD_BYTES)) rem_nx = REM_W'(s2_q - S2_W'(k * WORD_BYTES));
		end
	end

	assign rnd_res = (rem_q == '0) ? rnd_n_q : rnd_n_q + SIZE_W'(W_R - rem_q);
	assign req_eff = (req_q == '0) ? SIZE_W'(1) : SIZE_W'(req_q);

	// Capacity of a bulk about to be carved
	assign init_cap  = bypass_q ? SIZE_W'(bulk_bytes_q) : rnd_res;
	assign new_cap   = (SIZE_W'(bulk_bytes_q) < rnd_res) ? {rnd_res[SIZE_W-2:0], 1'b0}
		: SIZE_W'(bulk_bytes_q);
	assign carve_cap = started_q ? new_cap : init_cap;
	assign carve_sum = {1'b0, nb_q} + (NB_W+1)'(carve_cap);

	// Scan read port
	assign ri       = idx_q[IDX_W-1:0];
	assign rj       = live_q[IDX_W-1:0];
	assign rd_free  = free_q[ri];
	assign rd_cap   = cap_q[ri];
	assign rd_base  = base_q[ri];
	assign new_free = rd_free - rnd_res;

	always_comb begin
		st.started    = started_q;
		st.func       = func_q;
		st.rnd_done   = (cnt_q == STEP_W'(3));
		st.carve_fail = carve_sum > {1'b0, region_q};
		st.scan_end   = idx_q >= live_q;
		st.scan_hit   = rd_free >= rnd_res;
		st.hit_swap   = new_free < W_S;
		st.table_full = total_q == CNT_W'(MAX_BULKS);
		st.live_over  = live_q > total_q;
	end

	assign address = address_q;
	assign status  = status_q;

	// Config and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bulk_bytes_q    <= 33'd4194304;
			initial_bytes_q <= '0;
			region_q        <= NB_W'(1) << 40;
			total_q         <= '0;
			live_q          <= '0;
			idx_q           <= '0;
			nb_q            <= '0;
			started_q       <= 1'b0;
			cnt_q           <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BULK:    bulk_bytes_q <= cfg_data[32:0];
					REG_INITIAL: initial_bytes_q <= cfg_data[32:0];
					REG_REGION:  region_q <= cfg_data;
					default: ;
				endcase
			end
			case (op)
				OP_RND_INIT: cnt_q <= '0;
				OP_RND_REQ: begin
					cnt_q <= '0;
					idx_q <= '0;
				end
				OP_RND_STEP: cnt_q <= cnt_q + STEP_W'(1);
				OP_INIT_PUT: begin
					nb_q      <= carve_sum[NB_W-1:0];
					total_q   <= CNT_W'(1);
					live_q    <= CNT_W'(1);
					started_q <= 1'b1;
				end
				OP_FREE_ALL: live_q <= total_q;
				OP_SCAN_STEP: begin
					if (st.scan_hit) begin
						if (st.hit_swap) live_q <= live_q - CNT_W'(1);
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				OP_INSERT: begin
					nb_q    <= carve_sum[NB_W-1:0];
					total_q <= total_q + CNT_W'(1);
					live_q  <= live_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload: table, rounding and result registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				func_q <= func;
				req_q  <= request_bytes;
			end
			OP_RND_INIT: begin
				bypass_q <= initial_bytes_q == '0;
				rnd_n_q  <= (initial_bytes_q == '0) ? SIZE_W'(1) : SIZE_W'(initial_bytes_q);
				rem_q    <= '0;
			end
			OP_RND_REQ: begin
				bypass_q <= 1'b0;
				rnd_n_q  <= req_eff;
				rem_q    <= '0;
			end
			OP_RND_STEP: begin
				s1_q  <= s1_nx;
				s2_q  <= s2_nx;
				rem_q <= rem_nx;
			end
			OP_INIT_PUT: begin
				base_q[0] <= nb_q[BASE_W-1:0];
				cap_q[0]  <= init_cap;
				free_q[0] <= init_cap;
			end
			OP_FREE_ALL: begin
				for (int k = 0; k < MAX_BULKS; k++) begin
					if (CNT_W'(k) < total_q) free_q[k] <= cap_q[k];
				end
				res_addr_q   <= '0;
				res_status_q <= ST_FREE_ALL;
			end
			OP_SCAN_STEP: begin
				if (st.scan_hit) begin
					free_q[ri]   <= new_free;
					res_addr_q   <= rd_base + BASE_W'(rd_cap - rd_free);
					res_status_q <= ST_GRANT;
				end
			end
			OP_SWAP_WR: begin
				// live_q already points at the last live slot
				if (ri != rj) begin
					base_q[ri] <= base_q[rj];
					cap_q[ri]  <= cap_q[rj];
					free_q[ri] <= free_q[rj];
					base_q[rj] <= base_q[ri];
					cap_q[rj]  <= cap_q[ri];
					free_q[rj] <= free_q[ri];
				end
			end
			OP_INSERT: begin
				for (int k = MAX_BULKS - 1; k > 0; k--) begin
					base_q[k] <= base_q[k-1];
					cap_q[k]  <= cap_q[k-1];
					free_q[k] <= free_q[k-1];
				end
				base_q[0]    <= nb_q[BASE_W-1:0];
				cap_q[0]     <= new_cap;
				free_q[0]    <= new_cap - rnd_res;
				res_addr_q   <= nb_q[BASE_W-1:0];
				res_status_q <= ST_GRANT;
			end
			OP_RES_FULL: begin
				res_addr_q   <= '0;
				res_status_q <= ST_FULL;
			end
			OP_RES_REGION: begin
				res_addr_q   <= '0;
				res_status_q <= ST_REGION;
			end
			OP_OUT_LOAD: begin
				address_q <= res_addr_q;
				status_q  <= res_status_q;
			end
			default: ;
		endcase
	end
endmodule

[src/mbba_ctrl.sv]
// Controller state machine of the bump allocator unit.
// Depends on mbba_pkg.
module mbba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  mbba_pkg::dp_stat_t st,
	output mbba_pkg::dp_op_t   op
);
	import mbba_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RND_INIT,
		S_INIT_CHK,
		S_DISPATCH,
		S_RND_REQ,
		S_SCAN,
		S_SWAP,
		S_MISS,
		S_DONE
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q, out_valid_nx;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	// Decode command and next state
	always_comb begin
		op           = OP_NONE;
		state_nx     = state_q;
		out_valid_nx = out_valid_q && out_stall;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op       = OP_LOAD;
					state_nx = st.started ? S_DISPATCH : S_INIT_CHK;
					if (!st.started) state_nx = S_RND_INIT;
				end
			end
			S_RND_INIT: begin
				// loads the operand, then S_INIT_CHK steps until done
				op       = OP_RND_INIT;
				state_nx = S_INIT_CHK;
			end
			S_INIT_CHK: begin
				if (!st.rnd_done) begin
					op = OP_RND_STEP;
				end else if (st.carve_fail) begin
					op       = OP_RES_REGION;
					state_nx = S_DONE;
				end else begin
					op       = OP_INIT_PUT;
					state_nx = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (st.func) begin
					op       = OP_FREE_ALL;
					state_nx = S_DONE;
				end else begin
					op       = OP_RND_REQ;
					state_nx = S_RND_REQ;
				end
			end
			S_RND_REQ: begin
				op = OP_RND_STEP;
				if (st.rnd_done) begin
					op       = OP_NONE;
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_end) begin
					state_nx = S_MISS;
				end else begin
					op = OP_SCAN_STEP;
					if (st.scan_hit) state_nx = st.hit_swap ? S_SWAP : S_DONE;
				end
			end
			S_SWAP: begin
				op       = OP_SWAP_WR;
				state_nx = S_DONE;
			end
			S_MISS: begin
				if (st.table_full) op = OP_RES_FULL;
				else if (st.carve_fail) op = OP_RES_REGION;
				else op = OP_INSERT;
				state_nx = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					op           = OP_OUT_LOAD;
					out_valid_nx = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= out_valid_nx;
		end
	end
endmodule

[src/multi_bulk_bump_allocator_unit.sv]
// An allocation is dispatched, its size is rounded to whole words, then one scan step runs
// per bulk scanned and the result is loaded to the output; a hit that retires its bulk adds
// a swap step, and a miss adds a step that inserts a bulk or reports failure. Free all goes
// from dispatch to output. The first transaction after reset also forms the initial bulk.
// One transaction at a time; the next is accepted the cycle after its result is loaded.
// Reset: asynchronous, active low; clears control state and loads config defaults.
`include "multi_bulk_bump_allocator_unit_defines.svh"
module multi_bulk_bump_allocator_unit #(
	parameter int MAX_BULKS  = 16,
	parameter int WORD_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [mbba_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [mbba_pkg::REQ_W-1:0]  request_bytes,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mbba_pkg::BASE_W-1:0] address,
	output logic [1:0]                  status
);
	import mbba_pkg::*;

	dp_op_t   op;
	dp_stat_t st;

	mbba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.op        (op)
	);

	mbba_datapath #(
		.MAX_BULKS  (MAX_BULKS),
		.WORD_BYTES (WORD_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.request_bytes (request_bytes),
		.st            (st),
		.address       (address),
		.status        (status)
	);

	// Live bulks never outnumber formed bulks
	`MBBA_ASSERT_NEVER(a_live_le_total, clk, arst_n, st.live_over)
	// An accepted transaction blocks the input until its result is queued
	`MBBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule
